### rtl/fsed_pkg.sv
// Package for the fp32 squared L2 distance block: FSM and fold codes,
// register indexes, fold address tables and IEEE single add/multiply.
// No dependencies.
package fsed_pkg;

	localparam logic [31:0] QNAN = 32'h7FC0_0000;

	localparam logic [1:0] REG_VLEN = 2'd0;
	localparam logic [1:0] REG_MODE = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SUB, ST_MUL, ST_ACC, ST_CRD, ST_CFIRST, ST_CADD, ST_FIN
	} state_t;

	// fold kinds: sixteen-to-four, halving tree, final quad/single read
	typedef enum logic [1:0] {
		CH_F4, CH_HV, CH_Q
	} chain_t;

	// lane address of read k within fold group grp
	function automatic logic [3:0] ch_addr(input chain_t kind, input logic [3:0] grp,
		input logic [1:0] k);
		logic [3:0] base;
		logic [3:0] stride;
		base = 4'd0;
		stride = 4'd0;
		unique case (kind)
			CH_F4: return {k, grp[1:0]};
			CH_HV: begin
				if (grp < 4'd8) begin
					base = grp;
					stride = 4'd8;
				end else if (grp < 4'd12) begin
					base = grp - 4'd8;
					stride = 4'd4;
				end else if (grp < 4'd14) begin
					base = grp - 4'd12;
					stride = 4'd2;
				end else begin
					base = 4'd0;
					stride = 4'd1;
				end
				return k[0] ? base + stride : base;
			end
			CH_Q: return {2'b00, k};
			default: return 4'd0;
		endcase
	endfunction

	function automatic logic [1:0] ch_last_k(input chain_t kind, input logic mode);
		unique case (kind)
			CH_F4: return 2'd3;
			CH_HV: return 2'd1;
			CH_Q: return mode ? 2'd3 : 2'd0;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [3:0] ch_last_grp(input chain_t kind);
		unique case (kind)
			CH_F4: return 4'd3;
			CH_HV: return 4'd14;
			CH_Q: return 4'd0;
			default: return 4'd0;
		endcase
	endfunction

	function automatic logic [4:0] clz27(input logic [26:0] v);
		logic [4:0] n;
		n = 5'd27;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) n = 5'(26 - i);
		end
		return n;
	endfunction

	function automatic logic [5:0] clz48(input logic [47:0] v);
		logic [5:0] n;
		n = 6'd48;
		for (int i = 0; i < 48; i++) begin
			if (v[i]) n = 6'(47 - i);
		end
		return n;
	endfunction

	// m[26:3] significand (hidden bit at 26, clear only when e is 1), m[2:0] guard bits
	function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
		input logic [26:0] m);
		logic up;
		logic [24:0] mr;
		logic signed [11:0] e2;
		logic [22:0] frac;
		up = m[2] & (m[1] | m[0] | m[3]);
		mr = {1'b0, m[26:3]} + {24'd0, up};
		if (mr[24]) begin
			e2 = e + 12'sd1;
			frac = 23'd0;
		end else begin
			e2 = mr[23] ? e : 12'sd0;
			frac = mr[22:0];
		end
		if (e2 >= 12'sd255) return {s, 8'hFF, 23'd0};
		return {s, e2[7:0], frac};
	endfunction

	function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
		logic a_nan, b_nan, a_inf, b_inf;
		logic [31:0] x, y;
		logic [7:0] ex, ey, diff;
		logic [23:0] mx, my;
		logic [26:0] yx, ysh;
		logic st;
		logic [27:0] s;
		logic signed [11:0] e;
		logic [4:0] lz, sh;
		logic [26:0] m;
		a_nan = (&a[30:23]) && (|a[22:0]);
		b_nan = (&b[30:23]) && (|b[22:0]);
		a_inf = (&a[30:23]) && !(|a[22:0]);
		b_inf = (&b[30:23]) && !(|b[22:0]);
		if (a_nan || b_nan) return QNAN;
		if (a_inf && b_inf && (a[31] != b[31])) return QNAN;
		if (a_inf) return a;
		if (b_inf) return b;
		if (b[30:0] > a[30:0]) begin
			x = b;
			y = a;
		end else begin
			x = a;
			y = b;
		end
		ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
		ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
		mx = {|x[30:23], x[22:0]};
		my = {|y[30:23], y[22:0]};
		diff = ex - ey;
		yx = {my, 3'b000};
		if (diff > 8'd26) begin
			ysh = 27'd0;
			st = |my;
		end else begin
			ysh = yx >> diff;
			st = |(yx & ~(27'h7FF_FFFF << diff));
		end
		ysh = {ysh[26:1], ysh[0] | st};
		if (x[31] == y[31]) s = {1'b0, mx, 3'b000} + {1'b0, ysh};
		else s = {1'b0, mx, 3'b000} - {1'b0, ysh};
		if (s == 28'd0) return {a[31] & b[31], 31'd0};
		e = $signed({4'd0, ex});
		if (s[27]) begin
			m = {s[27:2], s[1] | s[0]};
			e = e + 12'sd1;
		end else begin
			lz = clz27(s[26:0]);
			if ($signed({7'd0, lz}) > e - 12'sd1) sh = 5'(e - 12'sd1);
			else sh = lz;
			m = s[26:0] << sh;
			e = e - $signed({7'd0, sh});
		end
		return round_pack(x[31], e, m);
	endfunction

	function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
		logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s;
		logic [7:0] ex, ey;
		logic [23:0] mx, my;
		logic [47:0] p, pn, q;
		logic [5:0] lz;
		logic signed [11:0] e, rs;
		logic st;
		a_nan = (&a[30:23]) && (|a[22:0]);
		b_nan = (&b[30:23]) && (|b[22:0]);
		a_inf = (&a[30:23]) && !(|a[22:0]);
		b_inf = (&b[30:23]) && !(|b[22:0]);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		s = a[31] ^ b[31];
		if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return QNAN;
		if (a_inf || b_inf) return {s, 8'hFF, 23'd0};
		if (a_zero || b_zero) return {s, 31'd0};
		ex = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		ey = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		mx = {|a[30:23], a[22:0]};
		my = {|b[30:23], b[22:0]};
		p = mx * my;
		lz = clz48(p);
		pn = p << lz;
		e = $signed({4'd0, ex}) + $signed({4'd0, ey}) - 12'sd126 - $signed({6'd0, lz});
		q = pn;
		st = 1'b0;
		if (e < 12'sd1) begin
			rs = 12'sd1 - e;
			if (rs > 12'sd47) begin
				q = 48'd0;
				st = |pn;
			end else begin
				q = pn >> rs[5:0];
				st = |(pn & ~({48{1'b1}} << rs[5:0]));
			end
			e = 12'sd1;
		end
		return round_pack(s, e, {q[47:22], (|q[21:0]) | st});
	endfunction

endpackage

### rtl/fp32_squared_euclidean_distance.sv
// Top level of the fp32 squared L2 distance block: sequencer, lane memory,
// shared fp adder and multiplier. Depends on fsed_pkg.
//
// channel  dir  handshake              word
// in       in   in_valid / in_ready    a_value, b_value (IEEE single bits)
// out      out  out_valid / out_ready  distance (IEEE single bits)
// cfg      in   cfg_wr_en (no wait)    cfg_index, cfg_data
//
// Each element pair is accepted, subtracted and squared, then added into its lane
// of the 16-entry lane memory (read-add-write, one read port) or, past the last full
// lane group, into the tail register. The fold to four lanes runs when needed; at a
// vector's end follow the halving fold and single read (mode 0) or quad sum (mode 1),
// then the tail add. Reset clears lane valid bits, so no clearing pass is needed.
// A finished distance waits in its output register; the next vector streams in
// meanwhile and only its final add stalls while the old word is not taken.
module fp32_squared_euclidean_distance (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] a_value,
	input  logic [31:0] b_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] distance,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	fsed_pkg::state_t state_q, state_d;
	fsed_pkg::chain_t kind_q, kind_d;

	logic [15:0] vlen_q;
	logic        mode_q;
	logic [15:0] idx_q;
	logic [31:0] tail_q;
	logic [15:0] lane_vld_q;
	logic        fin_q;
	logic        lane_path_q;
	logic [3:0]  grp_q;
	logic [1:0]  k_q;
	logic [31:0] a_q, b_q, d_q, p_q, acc_q;
	logic [31:0] out_q;
	logic        out_valid_q;

	logic [31:0] lane_mem [16];
	logic [31:0] mem_rd_q;
	logic [3:0]  rd_addr_q;

	logic [15:0] n_eff, n16, n4;
	logic        lane16, lane4;
	logic [31:0] lane_val;
	logic [31:0] add_a, add_b, add_y;
	logic [31:0] mul_y;

	// sequencer strobes
	logic        rd_en;
	logic [3:0]  rd_addr;
	logic        mem_we;
	logic [3:0]  mem_waddr;
	logic        ch_start;
	logic        grp_next;
	logic        k_next;
	logic        acc_load;
	logic        fin_set;
	logic        done;
	logic        cfg_hit;

	// a length of 0 counts as 1; the 16-bit register never exceeds the maximum
	assign n_eff = (vlen_q == 16'd0) ? 16'd1 : vlen_q;
	assign n16 = {n_eff[15:4], 4'd0};
	assign n4 = {n_eff[15:2], 2'd0};
	assign lane16 = idx_q < n16;
	assign lane4 = mode_q && (idx_q < n4);

	// a lane not written since the last clear reads as +0
	assign lane_val = lane_vld_q[rd_addr_q] ? mem_rd_q : 32'd0;

	assign cfg_hit = cfg_wr_en &&
		((cfg_index == fsed_pkg::REG_VLEN) || (cfg_index == fsed_pkg::REG_MODE));

	assign add_y = fsed_pkg::fp_add(add_a, add_b);
	assign mul_y = fsed_pkg::fp_mul(d_q, d_q);

	assign in_ready = (state_q == fsed_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign distance = out_q;

	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		rd_en = 1'b0;
		rd_addr = 4'd0;
		mem_we = 1'b0;
		mem_waddr = rd_addr_q;
		ch_start = 1'b0;
		grp_next = 1'b0;
		k_next = 1'b0;
		acc_load = 1'b0;
		fin_set = 1'b0;
		done = 1'b0;
		add_a = acc_q;
		add_b = lane_val;
		unique case (state_q)
			fsed_pkg::ST_IDLE: begin
				if (in_valid) begin
					// entering the four-lane phase: fold sixteen lanes first
					if (mode_q && (idx_q == n16) && (idx_q < n4)) begin
						ch_start = 1'b1;
						kind_d = fsed_pkg::CH_F4;
						state_d = fsed_pkg::ST_CRD;
					end else begin
						state_d = fsed_pkg::ST_SUB;
					end
				end
			end
			fsed_pkg::ST_SUB: begin
				add_a = a_q;
				add_b = {~b_q[31], b_q[30:0]};
				state_d = fsed_pkg::ST_MUL;
			end
			fsed_pkg::ST_MUL: begin
				rd_en = lane16 || lane4;
				rd_addr = lane16 ? idx_q[3:0] : {2'b00, idx_q[1:0]};
				state_d = fsed_pkg::ST_ACC;
			end
			fsed_pkg::ST_ACC: begin
				add_a = lane_path_q ? lane_val : tail_q;
				add_b = p_q;
				mem_we = lane_path_q;
				if (idx_q + 16'd1 >= n_eff) begin
					fin_set = 1'b1;
					ch_start = 1'b1;
					state_d = fsed_pkg::ST_CRD;
					if (!mode_q) kind_d = fsed_pkg::CH_HV;
					else if (n4 == n16) kind_d = fsed_pkg::CH_F4;
					else kind_d = fsed_pkg::CH_Q;
				end else begin
					state_d = fsed_pkg::ST_IDLE;
				end
			end
			fsed_pkg::ST_CRD: begin
				rd_en = 1'b1;
				rd_addr = fsed_pkg::ch_addr(kind_q, grp_q, 2'd0);
				state_d = fsed_pkg::ST_CFIRST;
			end
			fsed_pkg::ST_CFIRST: begin
				acc_load = 1'b1;
				if (fsed_pkg::ch_last_k(kind_q, mode_q) == 2'd0) begin
					done = 1'b1;
				end else begin
					rd_en = 1'b1;
					rd_addr = fsed_pkg::ch_addr(kind_q, grp_q, 2'd1);
					k_next = 1'b1;
					state_d = fsed_pkg::ST_CADD;
				end
			end
			fsed_pkg::ST_CADD: begin
				if (k_q == fsed_pkg::ch_last_k(kind_q, mode_q)) begin
					mem_we = (kind_q != fsed_pkg::CH_Q);
					mem_waddr = fsed_pkg::ch_addr(kind_q, grp_q, 2'd0);
					done = 1'b1;
				end else begin
					rd_en = 1'b1;
					rd_addr = fsed_pkg::ch_addr(kind_q, grp_q, k_q + 2'd1);
					k_next = 1'b1;
				end
			end
			fsed_pkg::ST_FIN: begin
				add_a = acc_q;
				add_b = tail_q;
				if (!out_valid_q || out_ready) state_d = fsed_pkg::ST_IDLE;
			end
			default: state_d = fsed_pkg::ST_IDLE;
		endcase
		// end of one fold group: next group, or what follows the fold
		if (done) begin
			if (grp_q != fsed_pkg::ch_last_grp(kind_q)) begin
				grp_next = 1'b1;
				state_d = fsed_pkg::ST_CRD;
			end else if (kind_q == fsed_pkg::CH_Q) begin
				state_d = fsed_pkg::ST_FIN;
			end else if ((kind_q == fsed_pkg::CH_F4) && !fin_q) begin
				state_d = fsed_pkg::ST_SUB;
			end else begin
				ch_start = 1'b1;
				kind_d = fsed_pkg::CH_Q;
				state_d = fsed_pkg::ST_CRD;
			end
		end
		if (cfg_hit) state_d = fsed_pkg::ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsed_pkg::ST_IDLE;
			kind_q <= fsed_pkg::CH_F4;
			vlen_q <= 16'd16;
			mode_q <= 1'b0;
			idx_q <= 16'd0;
			tail_q <= 32'd0;
			lane_vld_q <= 16'd0;
			fin_q <= 1'b0;
			grp_q <= 4'd0;
			k_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
			if (ch_start) begin
				grp_q <= 4'd0;
				k_q <= 2'd0;
			end else if (grp_next) begin
				grp_q <= grp_q + 4'd1;
				k_q <= 2'd0;
			end else if (k_next) begin
				k_q <= k_q + 2'd1;
			end
			if (fin_set) fin_q <= 1'b1;
			if (mem_we) lane_vld_q[mem_waddr] <= 1'b1;
			if (state_q == fsed_pkg::ST_ACC) begin
				if (!lane_path_q) tail_q <= add_y;
				idx_q <= fin_set ? 16'd0 : idx_q + 16'd1;
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			// result leaves; state back to an empty vector
			if ((state_q == fsed_pkg::ST_FIN) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				tail_q <= 32'd0;
				lane_vld_q <= 16'd0;
				fin_q <= 1'b0;
				idx_q <= 16'd0;
			end
			if (cfg_wr_en && (cfg_index == fsed_pkg::REG_VLEN)) vlen_q <= cfg_data;
			if (cfg_wr_en && (cfg_index == fsed_pkg::REG_MODE)) mode_q <= cfg_data[0];
			// any register write abandons the vector in progress
			if (cfg_hit) begin
				tail_q <= 32'd0;
				lane_vld_q <= 16'd0;
				fin_q <= 1'b0;
				idx_q <= 16'd0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			a_q <= a_value;
			b_q <= b_value;
		end
		if (state_q == fsed_pkg::ST_SUB) d_q <= add_y;
		if (state_q == fsed_pkg::ST_MUL) begin
			p_q <= mul_y;
			lane_path_q <= lane16 || lane4;
		end
		if (acc_load) acc_q <= lane_val;
		else if (state_q == fsed_pkg::ST_CADD) acc_q <= add_y;
		if ((state_q == fsed_pkg::ST_FIN) && (!out_valid_q || out_ready)) out_q <= add_y;
	end

	// lane memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) lane_mem[mem_waddr] <= add_y;
		if (rd_en) begin
			mem_rd_q <= lane_mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

endmodule
